FILE: sv/pwi_pkg.sv
// shared widths, register indexes and result type of the pulse window integrator
package pwi_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 12;
  localparam int IDX_W      = 12;
  localparam int SUM_W      = 24;
  localparam int CHAN_W     = 4;
  localparam int RISE_W     = 3;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  // parameter defaults
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_CHANNEL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISES_NEEDED = 1'd1;

  // configuration reset values
  localparam logic [CHAN_W-1:0] RST_SEL_CHANNEL  = 4'd13;
  localparam logic [RISE_W-1:0] RST_RISES_NEEDED = 3'd3;

  // one result word
  typedef struct packed {
    logic [SUM_W-1:0] pulse_integral;
    logic [IDX_W-1:0] leading_index;
    logic [IDX_W-1:0] trailing_index;
    logic             leading_found;
    logic             trailing_found;
  } pwi_result_t;

endpackage

FILE: sv/pwi_core.sv
// per-record edge search and window sum for the selected channel
module pwi_core #(
  parameter int MAX_SAMPLES = pwi_pkg::DEF_MAX_SAMPLES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [pwi_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last,
  input  logic [pwi_pkg::RISE_W-1:0]   rises_needed,
  output pwi_pkg::pwi_result_t         result
);
  import pwi_pkg::*;

  localparam int INDEX_LIMIT_I = ((MAX_SAMPLES - 1) < 4095) ? (MAX_SAMPLES - 1) : 4095;
  localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(INDEX_LIMIT_I);
  localparam logic [RISE_W-1:0] RISE_MAX = '1;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_TRAIL = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  phase_t              phase_r, phase_upd, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_upd, idx_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [RISE_W-1:0]   rise_cnt_r, rise_cnt_upd, rise_cnt_nxt;
  logic [IDX_W-1:0]    start_idx_r, start_idx_upd, start_idx_nxt;
  logic [SAMPLE_W-1:0] start_val_r, start_val_upd, start_val_nxt;
  logic [IDX_W-1:0]    end_idx_r, end_idx_upd, end_idx_nxt;
  logic [SUM_W-1:0]    sum_r, sum_upd, sum_nxt;

  logic [RISE_W-1:0]   need;
  logic [RISE_W-1:0]   rise_inc;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W+2:0] diff_x5;
  logic                is_rise;
  logic [SUM_W:0]      sum_ext;
  logic                lead_found, trail_found;

  // relative rise test: 5*(next-cur) > cur
  assign need     = (rises_needed == '0) ? RISE_W'(1) : rises_needed;
  assign rise_inc = (rise_cnt_r == RISE_MAX) ? RISE_MAX : rise_cnt_r + RISE_W'(1);
  assign diff     = sample - prev_r;
  assign diff_x5  = ({3'b000, diff} << 2) + {3'b000, diff};
  assign is_rise  = (sample > prev_r) && (diff_x5 > {3'b000, prev_r});
  assign sum_ext  = {1'b0, sum_r} + (SUM_W+1)'(sample);

  // edge search step
  always_comb begin
    phase_upd     = phase_r;
    idx_upd       = idx_r;
    rise_cnt_upd  = rise_cnt_r;
    start_idx_upd = start_idx_r;
    start_val_upd = start_val_r;
    end_idx_upd   = end_idx_r;
    sum_upd       = sum_r;
    unique case (phase_r)
      PH_LEAD: begin
        if (idx_r >= IDX_W'(2)) begin
          if (is_rise) begin
            rise_cnt_upd = rise_inc;
            if (rise_inc >= need) begin
              phase_upd     = PH_TRAIL;
              start_idx_upd = idx_r - IDX_W'(1);
              start_val_upd = prev_r;
              sum_upd       = SUM_W'(prev_r) + SUM_W'(sample);
            end
          end else begin
            rise_cnt_upd = '0;
          end
        end
      end
      PH_TRAIL: begin
        sum_upd = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (sample < start_val_r) begin
          end_idx_upd = idx_r;
          phase_upd   = PH_DONE;
        end
      end
      default: ;
    endcase
    if (idx_r < INDEX_LIMIT) begin
      idx_upd = idx_r + IDX_W'(1);
    end
  end

  // result word from the updated record state
  always_comb begin
    lead_found = (phase_upd != PH_LEAD);
    trail_found = (phase_upd != PH_LEAD) && (phase_upd != PH_TRAIL);
    result.pulse_integral = (lead_found && trail_found) ? sum_upd : '0;
    result.leading_index  = lead_found ? start_idx_upd : '0;
    result.trailing_index = trail_found ? end_idx_upd : '0;
    result.leading_found  = lead_found;
    result.trailing_found = trail_found;
  end

  // next state: hold, advance, or clear at record end
  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    rise_cnt_nxt  = rise_cnt_r;
    start_idx_nxt = start_idx_r;
    start_val_nxt = start_val_r;
    end_idx_nxt   = end_idx_r;
    sum_nxt       = sum_r;
    if (step) begin
      if (last) begin
        phase_nxt     = PH_LEAD;
        idx_nxt       = '0;
        prev_nxt      = '0;
        rise_cnt_nxt  = '0;
        start_idx_nxt = '0;
        start_val_nxt = '0;
        end_idx_nxt   = '0;
        sum_nxt       = '0;
      end else begin
        phase_nxt     = phase_upd;
        idx_nxt       = idx_upd;
        prev_nxt      = sample;
        rise_cnt_nxt  = rise_cnt_upd;
        start_idx_nxt = start_idx_upd;
        start_val_nxt = start_val_upd;
        end_idx_nxt   = end_idx_upd;
        sum_nxt       = sum_upd;
      end
    end
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      idx_r       <= '0;
      prev_r      <= '0;
      rise_cnt_r  <= '0;
      start_idx_r <= '0;
      start_val_r <= '0;
      end_idx_r   <= '0;
      sum_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      prev_r      <= prev_nxt;
      rise_cnt_r  <= rise_cnt_nxt;
      start_idx_r <= start_idx_nxt;
      start_val_r <= start_val_nxt;
      end_idx_r   <= end_idx_nxt;
      sum_r       <= sum_nxt;
    end
  end

endmodule

FILE: sv/pulse_window_integrator.sv
// top level: configuration registers, channel filter and result register
//
// Input channel: one digitizer sample word per accepted cycle (value, channel
// tag, last-sample mark). Words of channels other than the selected one are
// accepted and dropped, last-sample mark included.
// Output channel: one result word per record of the selected channel, given
// for the word carrying the last-sample mark: window sum, leading and
// trailing edge indices and their found flags.
// Latency: the result is valid in the cycle after the last sample is taken.
// Throughput: one sample word per clock; the only stored stage on the data
// path is the result register, so in_stall rises only while a result is
// held and out_stall is high.
// Configuration: cfg_we writes selected_channel (index 0) or rises_needed
// (index 1); write only while the block is idle.
// Reset (rst_n low, synchronous): selected_channel 13, rises_needed 3,
// record state cleared, result register empty.
module pulse_window_integrator #(
  parameter int MAX_SAMPLES = pwi_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pwi_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pwi_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic [pwi_pkg::CHAN_W-1:0]     in_channel_tag,
  input  logic                           in_last_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pwi_pkg::SUM_W-1:0]      out_pulse_integral,
  output logic [pwi_pkg::IDX_W-1:0]      out_leading_index,
  output logic [pwi_pkg::IDX_W-1:0]      out_trailing_index,
  output logic                           out_leading_found,
  output logic                           out_trailing_found,
  input  logic                           cfg_we,
  input  logic [pwi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwi_pkg::*;

  localparam int MASK_I = (SAMPLE_BITS >= SAMPLE_W) ? ((1 << SAMPLE_W) - 1)
                                                    : ((1 << SAMPLE_BITS) - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'(MASK_I);

  logic [CHAN_W-1:0] sel_channel_r;
  logic [RISE_W-1:0] rises_needed_r;
  logic              out_valid_r;
  pwi_result_t       out_res_r;
  pwi_result_t       core_res;
  logic              in_take;
  logic              step;

  // handshake and channel filter
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign step     = in_take && (in_channel_tag == sel_channel_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_channel_r  <= RST_SEL_CHANNEL;
      rises_needed_r <= RST_RISES_NEEDED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEL_CHANNEL:  sel_channel_r  <= cfg_data[CHAN_W-1:0];
        CFG_RISES_NEEDED: rises_needed_r <= cfg_data[RISE_W-1:0];
        default: ;
      endcase
    end
  end

  pwi_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .sample       (in_sample_value & SAMPLE_MASK),
    .last         (in_last_sample),
    .rises_needed (rises_needed_r),
    .result       (core_res)
  );

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_sample) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step && in_last_sample) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pulse_integral = out_res_r.pulse_integral;
  assign out_leading_index  = out_res_r.leading_index;
  assign out_trailing_index = out_res_r.trailing_index;
  assign out_leading_found  = out_res_r.leading_found;
  assign out_trailing_found = out_res_r.trailing_found;

`ifndef SYNTHESIS
  // a trailing edge is only searched for after a leading edge
  a_trail_needs_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trailing_found |-> out_leading_found)
    else $error("trailing edge reported without leading edge");

  // a missing edge gives an empty window
  a_no_edge_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_trailing_found |-> out_pulse_integral == '0)
    else $error("nonzero integral without both edges");

  // the trailing edge lies after the leading edge
  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trailing_found |-> out_trailing_index > out_leading_index)
    else $error("trailing index not after leading index");

  // a held result blocks the input side
  a_stall_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result is held");
`endif

endmodule
